@@ src/pdht_pkg.sv @@
// Shared constants, types and state encoding for the duplicate-packet history table.
// Used by the core; the generic RAM takes no types from this package.
package pdht_pkg;

   localparam int ENTRIES    = 32;
   localparam int RELAYERS   = 3;
   localparam int IDX_W      = $clog2(ENTRIES);
   localparam int CNT_W      = $clog2(ENTRIES + 1);
   localparam int KEY_W      = 32;
   localparam int TIME_W     = 32;
   localparam int HOP_W      = 3;
   localparam int RELAYER_W  = 8;
   localparam int USED_W     = 6;
   localparam int USED_MAX   = 63;
   localparam int KIND_W     = 2;
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [KIND_W-1:0] {
      KIND_CHECK_ADD = 2'd0,
      KIND_QUERY     = 2'd1,
      KIND_REMOVE    = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE
   } state_type;

   typedef logic [RELAYERS-1:0][RELAYER_W-1:0] relay_list_type;

   // One table entry as stored in the entry RAM.
   typedef struct packed {
      logic [KEY_W-1:0]  sender;
      logic [KEY_W-1:0]  packet_id;
      logic [TIME_W-1:0] seen_time;
      logic [HOP_W-1:0]  highest_hop;
      relay_list_type    relayers;
   } row_type;

   localparam int ROW_W = $bits(row_type);

endpackage

@@ src/pdht_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module pdht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

@@ src/packet_dedup_history_table_core.sv @@
// Duplicate-packet history table core for flood routing.
// Depends on pdht_pkg and instantiates pdht_ram for the entry storage.

// Each request word carries a packet key (sender, packet id), a hop limit, a relayer
// byte and the current time; tuser selects the operation: check-and-add, query
// relayer or remove relayer (code 3 does nothing). Every request yields exactly one
// response word with the seen/upgrade/listed flags and the number of used entries
// after the operation. The block handles one request at a time: each one goes
// through a linear scan that reads the entry RAM through its single read port one
// entry per cycle and runs every entry through one key/time comparator, then a
// drain step and an update step. A new request is accepted only once that update
// step is done and the block is idle again. The scan finds the matching entry,
// the first free entry and the oldest entry (lowest index on equal times) in the
// same pass, and the update step then writes the chosen entry if the operation
// changes it. A finished response waits in its output register; while it is not
// taken the next request may still be accepted and scanned, and only its update
// step waits. Entry valid bits are flip-flops cleared by reset, so there is no
// clearing pass; the entry RAM is never cleared, because a slot is only used while
// valid and an allocation writes the whole entry, relayer list included.
module packet_dedup_history_table_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // sender[31:0], packet_id[63:32], hop_count[66:64], relayer[74:67],
   // now_time[106:75], zero pad[111:107]
   input  logic [pdht_pkg::REQ_DATA_W-1:0]  req_tdata,
   // kind[1:0]
   input  logic [pdht_pkg::KIND_W-1:0]      req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // seen_before[0], hop_upgraded[1], relayer_listed[2], used_entries[8:3],
   // zero pad[15:9]
   output logic [pdht_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   import pdht_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   // Sequencer and control state.
   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    scan_addr_ff, scan_addr_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]    cmp_idx_ff, cmp_idx_in;
   logic [ENTRIES-1:0]  valid_ff, valid_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;

   // Scan results.
   logic                hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]    hit_idx_ff, hit_idx_in;
   row_type             hit_row_ff, hit_row_in;
   logic                free_found_ff, free_found_in;
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in;
   logic                best_have_ff, best_have_in;
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   logic [TIME_W-1:0]   best_time_ff, best_time_in;

   // Latched request fields.
   kind_type            kind_ff, kind_in;
   logic [KEY_W-1:0]    sender_ff, sender_in;
   logic [KEY_W-1:0]    packet_id_ff, packet_id_in;
   logic [HOP_W-1:0]    hop_ff, hop_in;
   logic [RELAYER_W-1:0] relayer_ff, relayer_in;
   logic [TIME_W-1:0]   now_ff, now_in;

   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Sequencer outputs.
   logic                accept;
   logic                rd_en;
   logic                upd_go;

   // Entry RAM.
   logic [ROW_W-1:0]    rd_data;
   row_type             rd_row;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   row_type             wr_row;

   // Update step.
   logic [IDX_W-1:0]    target_idx;
   logic                alloc;
   logic                seen_bit;
   logic                upg_bit;
   logic                listed_bit;
   logic [CNT_W-1:0]    count_upd;
   logic [USED_W-1:0]   used_val;

   // Adds a relayer: zero and duplicates are ignored, a hole is filled first, and
   // a full list drops its oldest member.
   function automatic relay_list_type list_add(relay_list_type lst,
                                               logic [RELAYER_W-1:0] r);
      relay_list_type res;
      logic present;
      logic placed;
      res     = lst;
      present = 1'b0;
      placed  = 1'b0;
      for (int i = 0; i < RELAYERS; i++) begin
         if (lst[i] == r) present = 1'b1;
      end
      if (r != '0 && !present) begin
         for (int i = 0; i < RELAYERS; i++) begin
            if (!placed && lst[i] == '0) begin
               res[i] = r;
               placed = 1'b1;
            end
         end
         if (!placed) begin
            for (int i = 0; i < RELAYERS - 1; i++) begin
               res[i] = lst[i + 1];
            end
            res[RELAYERS - 1] = r;
         end
      end
      return res;
   endfunction

   function automatic logic list_has(relay_list_type lst, logic [RELAYER_W-1:0] r);
      logic found;
      found = 1'b0;
      for (int i = 0; i < RELAYERS; i++) begin
         if (lst[i] == r) found = 1'b1;
      end
      return found;
   endfunction

   // Clears the first slot that holds the relayer.
   function automatic relay_list_type list_remove(relay_list_type lst,
                                                  logic [RELAYER_W-1:0] r);
      relay_list_type res;
      logic done;
      res  = lst;
      done = 1'b0;
      for (int i = 0; i < RELAYERS; i++) begin
         if (!done && lst[i] == r) begin
            res[i] = '0;
            done   = 1'b1;
         end
      end
      return res;
   endfunction

   pdht_ram #(
      .WIDTH (ROW_W),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_row),
      .rd_en   (rd_en),
      .rd_addr (scan_addr_ff),
      .rd_data (rd_data)
   );

   assign rd_row = row_type'(rd_data);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_addr_ff == LAST_IDX) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (!rsp_tvalid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs. The update step waits only while the previous response
   // is still held in the output register.
   always_comb begin
      req_tready = 1'b0;
      rd_en      = 1'b0;
      upd_go     = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_SCAN:   rd_en      = 1'b1;
         ST_DRAIN:  ;
         ST_UPDATE: upd_go     = !rsp_tvalid_ff || rsp_tready;
         default:   ;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // Update step: pick the entry to touch and build its new contents.
   always_comb begin
      if (hit_found_ff) begin
         target_idx = hit_idx_ff;
      end else if (free_found_ff) begin
         target_idx = free_idx_ff;
      end else begin
         target_idx = best_idx_ff;
      end

      wr_row     = hit_row_ff;
      wr_en      = 1'b0;
      alloc      = 1'b0;
      seen_bit   = 1'b0;
      upg_bit    = 1'b0;
      listed_bit = 1'b0;

      unique case (kind_ff)
         KIND_CHECK_ADD: begin
            wr_en = upd_go;
            if (hit_found_ff) begin
               seen_bit = 1'b1;
               if (hop_ff > hit_row_ff.highest_hop) begin
                  upg_bit            = 1'b1;
                  wr_row.highest_hop = hop_ff;
               end
               wr_row.seen_time = now_ff;
               wr_row.relayers  = list_add(hit_row_ff.relayers, relayer_ff);
            end else begin
               alloc              = 1'b1;
               wr_row.sender      = sender_ff;
               wr_row.packet_id   = packet_id_ff;
               wr_row.seen_time   = now_ff;
               wr_row.highest_hop = hop_ff;
               wr_row.relayers    = list_add('0, relayer_ff);
            end
         end
         KIND_QUERY: begin
            listed_bit = hit_found_ff && relayer_ff != '0
                         && list_has(hit_row_ff.relayers, relayer_ff);
         end
         KIND_REMOVE: begin
            if (hit_found_ff && relayer_ff != '0) begin
               wr_en           = upd_go;
               wr_row.relayers = list_remove(hit_row_ff.relayers, relayer_ff);
            end
         end
         default: ;
      endcase

      wr_addr = target_idx;

      // A new allocation into a free slot is the only way the count grows.
      count_upd = count_ff;
      if (alloc && !valid_ff[target_idx]) begin
         count_upd = count_ff + CNT_W'(1);
      end
      if (int'(count_upd) > USED_MAX) begin
         used_val = USED_W'(USED_MAX);
      end else begin
         used_val = USED_W'(count_upd);
      end
   end

   // Register next values: request capture, scan comparator, update and response.
   always_comb begin
      scan_addr_in  = scan_addr_ff;
      cmp_vld_in    = rd_en;
      cmp_idx_in    = scan_addr_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_row_in    = hit_row_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      best_have_in  = best_have_ff;
      best_idx_in   = best_idx_ff;
      best_time_in  = best_time_ff;
      kind_in       = kind_ff;
      sender_in     = sender_ff;
      packet_id_in  = packet_id_ff;
      hop_in        = hop_ff;
      relayer_in    = relayer_ff;
      now_in        = now_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;

      if (accept) begin
         kind_in       = kind_type'(req_tuser);
         sender_in     = req_tdata[31:0];
         packet_id_in  = req_tdata[63:32];
         hop_in        = req_tdata[66:64];
         relayer_in    = req_tdata[74:67];
         now_in        = req_tdata[106:75];
         scan_addr_in  = '0;
         hit_found_in  = 1'b0;
         free_found_in = 1'b0;
         best_have_in  = 1'b0;
      end

      if (rd_en && scan_addr_ff != LAST_IDX) begin
         scan_addr_in = scan_addr_ff + IDX_W'(1);
      end

      // One entry per cycle through the shared comparator.
      if (cmp_vld_ff) begin
         if (valid_ff[cmp_idx_ff]) begin
            if (!hit_found_ff && rd_row.sender == sender_ff
                && rd_row.packet_id == packet_id_ff) begin
               hit_found_in = 1'b1;
               hit_idx_in   = cmp_idx_ff;
               hit_row_in   = rd_row;
            end
            if (!best_have_ff || rd_row.seen_time < best_time_ff) begin
               best_have_in = 1'b1;
               best_idx_in  = cmp_idx_ff;
               best_time_in = rd_row.seen_time;
            end
         end else if (!free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = cmp_idx_ff;
         end
      end

      if (upd_go) begin
         if (alloc) valid_in[target_idx] = 1'b1;
         count_in      = count_upd;
         rsp_tvalid_in = 1'b1;
         rsp_data_in   = {{(RSP_DATA_W - USED_W - 3){1'b0}}, used_val,
                          listed_bit, upg_bit, seen_bit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cmp_vld_ff    <= 1'b0;
         valid_ff      <= '0;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         best_have_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cmp_vld_ff    <= cmp_vld_in;
         valid_ff      <= valid_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         hit_found_ff  <= hit_found_in;
         free_found_ff <= free_found_in;
         best_have_ff  <= best_have_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_addr_ff <= scan_addr_in;
      cmp_idx_ff   <= cmp_idx_in;
      hit_idx_ff   <= hit_idx_in;
      hit_row_ff   <= hit_row_in;
      free_idx_ff  <= free_idx_in;
      best_idx_ff  <= best_idx_in;
      best_time_ff <= best_time_in;
      kind_ff      <= kind_in;
      sender_ff    <= sender_in;
      packet_id_ff <= packet_id_in;
      hop_ff       <= hop_in;
      relayer_ff   <= relayer_in;
      now_ff       <= now_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // The used-entry count always matches the valid bits.
   assert_count_matches: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) == $countones(valid_ff))
      else $error("used-entry count out of step with valid bits");

   // A new response only appears from the update step.
   assert_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_UPDATE))
      else $error("response raised outside the update step");

   // The comparator only sees data for reads issued during the scan.
   assert_cmp_after_read: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> $past(state_ff == ST_SCAN))
      else $error("comparator active without a scan read");
`endif

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for packet_dedup_history_table_core: stream driver, stream monitor,
// and a predictor of the duplicate-packet history table. Depends on pdht_pkg and the core RTL.
module testbench;
   import pdht_pkg::*;

   // The kind field uses code 3 as a no-op; the package enum leaves it unnamed.
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int HOT_KEYS      = 48;    // more keys in play than entries, so eviction occurs
   localparam int RANDOM_WORDS  = 1400;
   localparam int HOLD_EVERY    = 350;   // random words between full drains of the pipeline
   localparam int SETTLE_CYCLES = ENTRIES + 8;

   typedef struct {
      logic [KIND_W-1:0]    kind;
      logic [KEY_W-1:0]     sender;
      logic [KEY_W-1:0]     packet_id;
      logic [HOP_W-1:0]     hop;
      logic [RELAYER_W-1:0] relayer;
      logic [TIME_W-1:0]    now_ms;
      bit                   hold;      // wait for every response before sending this word
   } packet_word_type;

   typedef struct {
      logic              seen;
      logic              upgraded;
      logic              listed;
      logic [USED_W-1:0] used;
   } verdict_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_COIN,
      STALL_SPARSE,
      STALL_PERIODIC
   } stall_mode_type;

   // DUT connections. Every input starts at a known value.
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [KIND_W-1:0]     req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   packet_dedup_history_table_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Shadow copy of the history table, kept in step with every accepted request word.
   bit                   hist_valid  [ENTRIES];
   logic [KEY_W-1:0]     hist_sender [ENTRIES];
   logic [KEY_W-1:0]     hist_pid    [ENTRIES];
   logic [TIME_W-1:0]    hist_time   [ENTRIES];
   logic [HOP_W-1:0]     hist_hop    [ENTRIES];
   logic [RELAYER_W-1:0] hist_relay  [ENTRIES][RELAYERS];

   packet_word_type pending_words[$];     // stimulus not yet presented to the DUT
   verdict_type     awaited_verdicts[$];  // predicted responses in arrival order
   packet_word_type cur_word;

   // Both counters move by nonblocking assignment so that each side reads the
   // other's value from before the clock edge.
   int sent_count    = 0;
   int checked_count = 0;
   int error_count   = 0;

   // Coverage tallies for the closing summary.
   int n_miss = 0, n_hit = 0, n_evict = 0, n_upgrade = 0, n_listed = 0, n_removed = 0;
   int n_shift = 0;

   // Adding a relayer: zero and duplicates are ignored, a hole left by a remove is
   // reused first, and a full list drops its oldest member from slot zero.
   function automatic void push_relay(input int slot, input logic [RELAYER_W-1:0] rel);
      int  j;
      bit  done;
      done = (rel == '0);
      for (j = 0; j < RELAYERS; j++)
         if (hist_relay[slot][j] == rel) done = 1'b1;
      for (j = 0; j < RELAYERS && !done; j++)
         if (hist_relay[slot][j] == '0) begin
            hist_relay[slot][j] = rel;
            done = 1'b1;
         end
      if (!done) begin
         for (j = 0; j < RELAYERS - 1; j++)
            hist_relay[slot][j] = hist_relay[slot][j + 1];
         hist_relay[slot][RELAYERS - 1] = rel;
         n_shift++;
      end
   endfunction

   // Applies one request word to the shadow table and returns the response it must produce.
   function automatic verdict_type predict_history(input packet_word_type w);
      verdict_type       v;
      int                hit;
      int                slot;
      int                used;
      int                i;
      bit                cleared;
      logic [TIME_W-1:0] oldest;
      v = '{seen: 1'b0, upgraded: 1'b0, listed: 1'b0, used: '0};
      hit = -1;
      for (i = 0; i < ENTRIES && hit < 0; i++)
         if (hist_valid[i] && hist_sender[i] == w.sender && hist_pid[i] == w.packet_id)
            hit = i;

      if (w.kind == KIND_CHECK_ADD) begin
         if (hit < 0) begin
            // Lowest free entry first; otherwise the oldest time, lowest index on a tie.
            slot = -1;
            for (i = 0; i < ENTRIES; i++)
               if (!hist_valid[i] && slot < 0) slot = i;
            if (slot < 0) begin
               slot   = 0;
               oldest = hist_time[0];
               for (i = 1; i < ENTRIES; i++)
                  if (hist_time[i] < oldest) begin
                     slot   = i;
                     oldest = hist_time[i];
                  end
               n_evict++;
            end
            hist_valid[slot]  = 1'b1;
            hist_sender[slot] = w.sender;
            hist_pid[slot]    = w.packet_id;
            hist_time[slot]   = w.now_ms;
            hist_hop[slot]    = w.hop;
            for (i = 0; i < RELAYERS; i++) hist_relay[slot][i] = '0;
            push_relay(slot, w.relayer);
            n_miss++;
         end else begin
            v.seen = 1'b1;
            if (w.hop > hist_hop[hit]) begin
               hist_hop[hit] = w.hop;
               v.upgraded    = 1'b1;
               n_upgrade++;
            end
            hist_time[hit] = w.now_ms;
            push_relay(hit, w.relayer);
            n_hit++;
         end
      end else if ((w.kind == KIND_QUERY || w.kind == KIND_REMOVE) && hit >= 0
                   && w.relayer != '0) begin
         cleared = 1'b0;
         for (i = 0; i < RELAYERS && !cleared; i++)
            if (hist_relay[hit][i] == w.relayer) begin
               cleared = 1'b1;
               if (w.kind == KIND_QUERY) begin
                  v.listed = 1'b1;
                  n_listed++;
               end else begin
                  hist_relay[hit][i] = '0;
                  n_removed++;
               end
            end
      end

      used = 0;
      for (i = 0; i < ENTRIES; i++)
         if (hist_valid[i]) used++;
      v.used = (used > USED_MAX) ? USED_W'(USED_MAX) : USED_W'(used);
      return v;
   endfunction

   task automatic queue_word(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] snd,
                             input logic [KEY_W-1:0] pid, input logic [HOP_W-1:0] hop,
                             input logic [RELAYER_W-1:0] rel, input logic [TIME_W-1:0] t,
                             input bit hold);
      packet_word_type w;
      w = '{kind: kind, sender: snd, packet_id: pid, hop: hop, relayer: rel, now_ms: t,
            hold: hold};
      pending_words.push_back(w);
   endtask

   // Driver. Words go out in bursts of random length separated by random gaps, so
   // that new words land on every phase of the DUT's request handling. A word
   // marked hold is kept back until every earlier response has been checked.
   int  burst_left = 1;
   int  gap_left   = 0;
   int  outstanding;
   bit  accepted;
   verdict_type predicted;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         accepted = req_tvalid && req_tready;
         outstanding = sent_count - checked_count - int'(rsp_tvalid && rsp_tready);
         if (accepted) begin
            predicted = predict_history(cur_word);
            awaited_verdicts.push_back(predicted);
            sent_count <= sent_count + 1;
            outstanding++;
         end
         if (!req_tvalid || accepted) begin
            if (gap_left != 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_words.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (pending_words[0].hold && outstanding != 0) begin
               req_tvalid <= 1'b0;
            end else begin
               cur_word   = pending_words.pop_front();
               req_tvalid <= 1'b1;
               // sender, packet_id, hop count, relayer, now_time from the lowest bit up
               req_tdata  <= {5'b0, cur_word.now_ms, cur_word.relayer, cur_word.hop,
                              cur_word.packet_id, cur_word.sender};
               req_tuser  <= cur_word.kind;
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 12);
                  case ($urandom_range(0, 3))
                     0:       gap_left = 0;
                     1:       gap_left = $urandom_range(1, 5);
                     2:       gap_left = $urandom_range(10, 40);
                     default: gap_left = $urandom_range(30, 80);
                  endcase
               end
            end
         end
      end
   end

   // Receiver back-pressure. A new stall pattern is picked whenever the low byte of
   // stall_cycle is zero: always ready, a coin toss, rare acceptance, or a fixed duty cycle.
   logic [15:0]    stall_cycle = '0;
   stall_mode_type stall_mode  = STALL_NONE;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         stall_cycle <= '0;
         stall_mode  <= STALL_NONE;
      end else begin
         stall_cycle <= stall_cycle + 16'd1;
         if (stall_cycle[7:0] == 8'd0)
            stall_mode <= stall_mode_type'($urandom_range(0, 3));
         case (stall_mode)
            STALL_NONE:   rsp_tready <= 1'b1;
            STALL_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            STALL_SPARSE: rsp_tready <= ($urandom_range(0, 7) == 0);
            default:      rsp_tready <= (stall_cycle[3:0] < 4'd5);
         endcase
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // Monitor. Each accepted response word is checked against the oldest prediction.
   verdict_type want;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (checked_count >= sent_count) begin
            $error("response word with no request outstanding: %h", rsp_tdata);
            error_count++;
         end else begin
            want = awaited_verdicts.pop_front();
            check_field("seen_before",    want.seen,     rsp_tdata[0]);
            check_field("hop_upgraded",   want.upgraded, rsp_tdata[1]);
            check_field("relayer_listed", want.listed,   rsp_tdata[2]);
            check_field("used_entries",   want.used,     rsp_tdata[8:3]);
            checked_count <= checked_count + 1;
         end
      end
   end

   // Random stimulus. Most words reuse a pool of hot keys so hits, upgrades, relayer
   // list churn and evictions all happen; the rest bring fresh random keys.
   logic [KEY_W-1:0]  pool_sender [HOT_KEYS];
   logic [KEY_W-1:0]  pool_pid    [HOT_KEYS];
   int                pool_fill = 0;
   logic [TIME_W-1:0] clock_ms  = 32'd1000;

   task automatic queue_random_word(input bit hold);
      logic [KIND_W-1:0]    kind;
      logic [KEY_W-1:0]     snd;
      logic [KEY_W-1:0]     pid;
      logic [RELAYER_W-1:0] rel;
      logic [TIME_W-1:0]    t;
      int                   pick;
      int                   r;
      r = $urandom_range(0, 99);
      if (r < 55)      kind = KIND_CHECK_ADD;
      else if (r < 75) kind = KIND_QUERY;
      else if (r < 93) kind = KIND_REMOVE;
      else             kind = KIND_UNUSED;

      if (pool_fill > 0 && $urandom_range(0, 9) < 8) begin
         pick = $urandom_range(0, pool_fill - 1);
         snd  = pool_sender[pick];
         pid  = pool_pid[pick];
      end else begin
         snd = $urandom;
         pid = $urandom;
         // A fresh key that shares its sender with a hot key checks the full-key match.
         if (pool_fill > 0 && $urandom_range(0, 4) == 0)
            snd = pool_sender[$urandom_range(0, pool_fill - 1)];
         if (pool_fill < HOT_KEYS) begin
            pick = pool_fill;
            pool_fill++;
         end else begin
            pick = $urandom_range(0, HOT_KEYS - 1);
         end
         pool_sender[pick] = snd;
         pool_pid[pick]    = pid;
      end

      r = $urandom_range(0, 9);
      if (r == 0)     rel = '0;
      else if (r < 7) rel = RELAYER_W'($urandom_range(1, 5));
      else            rel = RELAYER_W'($urandom_range(0, 255));

      // Time mostly creeps forward, with repeats for eviction ties and the odd jump.
      if ($urandom_range(0, 19) == 0) begin
         t = $urandom;
      end else begin
         clock_ms = clock_ms + TIME_W'($urandom_range(0, 3));
         t = clock_ms;
      end
      queue_word(kind, snd, pid, HOP_W'($urandom_range(0, 7)), rel, t, hold);
   endtask

   initial begin : stimulus
      int k;
      // Directed opening on three extreme keys: relayer zero, hop upgrade and no
      // upgrade, duplicate relayer, list overflow with shift, hole from a remove
      // and its reuse, unknown key, and the unused kind.
      queue_word(KIND_CHECK_ADD, 32'h0, 32'h0, 3'd0, 8'h00, 32'h0, 1'b0);
      queue_word(KIND_QUERY,     32'h0, 32'h0, 3'd0, 8'h00, 32'h0, 1'b0);
      queue_word(KIND_CHECK_ADD, 32'h0, 32'h0, 3'd7, 8'hFF, 32'hFFFF_FFFF, 1'b0);
      queue_word(KIND_CHECK_ADD, 32'h0, 32'h0, 3'd3, 8'hFF, 32'h5, 1'b0);
      queue_word(KIND_CHECK_ADD, 32'h0, 32'h0, 3'd7, 8'h01, 32'h6, 1'b0);
      queue_word(KIND_CHECK_ADD, 32'h0, 32'h0, 3'd0, 8'h02, 32'h7, 1'b0);
      queue_word(KIND_CHECK_ADD, 32'h0, 32'h0, 3'd1, 8'h03, 32'h8, 1'b0);
      queue_word(KIND_QUERY,     32'h0, 32'h0, 3'd0, 8'hFF, 32'h0, 1'b0);
      queue_word(KIND_QUERY,     32'h0, 32'h0, 3'd0, 8'h02, 32'h0, 1'b0);
      queue_word(KIND_REMOVE,    32'h0, 32'h0, 3'd0, 8'h02, 32'h0, 1'b0);
      queue_word(KIND_REMOVE,    32'h0, 32'h0, 3'd0, 8'h00, 32'h0, 1'b0);
      queue_word(KIND_QUERY,     32'h0, 32'h0, 3'd0, 8'h02, 32'h0, 1'b0);
      queue_word(KIND_CHECK_ADD, 32'h0, 32'h0, 3'd0, 8'h04, 32'h9, 1'b0);
      queue_word(KIND_QUERY,     32'h0, 32'h0, 3'd0, 8'h04, 32'h0, 1'b0);
      queue_word(KIND_QUERY,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 8'h01, 32'h0, 1'b0);
      queue_word(KIND_REMOVE,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 8'h01, 32'h0, 1'b0);
      queue_word(KIND_UNUSED,    32'h0, 32'h0, 3'd7, 8'h01, 32'hFFFF_FFFF, 1'b0);
      queue_word(KIND_CHECK_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 8'h80, 32'h0, 1'b0);
      queue_word(KIND_CHECK_ADD, 32'hFFFF_FFFF, 32'h0, 3'd2, 8'h7F, 32'h0, 1'b0);
      queue_word(KIND_QUERY,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0, 8'h80, 32'h0, 1'b0);
      pool_sender[0] = 32'h0;         pool_pid[0] = 32'h0;
      pool_sender[1] = 32'hFFFF_FFFF; pool_pid[1] = 32'hFFFF_FFFF;
      pool_fill = 2;

      for (k = 0; k < RANDOM_WORDS; k++)
         queue_random_word(k % HOLD_EVERY == 0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_tvalid) @(posedge clock);
      while (checked_count != sent_count) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Checked %0d responses: %0d misses (%0d evictions), %0d hits, %0d hop upgrades.",
               checked_count, n_miss, n_evict, n_hit, n_upgrade);
      $display("Relayer lists: %0d overflow shifts, %0d listed queries, %0d removals.",
               n_shift, n_listed, n_removed);
      if (error_count == 0 && awaited_verdicts.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Watchdog: a correct run needs well under a fifth of this time.
   initial begin : watchdog
      #20_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
